FILE: hw/rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// NAL start code splitter package
// Shared result types, queue sizing and output field widths.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // Width of the zero count field on the result side.
    localparam int ZEROS_OUT_BITS = 16;

    // Result queue between the parser and the output port.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_LEVEL_BITS = 3;

    // One result request as it leaves the block.
    typedef struct packed {
        logic                      final_for_input;
        logic                      last_of_unit;
        logic                      first_of_unit;
        logic                      zeros_saturated;
        logic [ZEROS_OUT_BITS-1:0] zeros_before;
        logic [7:0]                unit_byte;
    } result_t;

    // Push group from the parser into the queue. When only one result is
    // pushed it sits in res0.
    typedef struct packed {
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } push_t;

    // Queue status back to the parser and the top level.
    typedef struct packed {
        logic                        ready;
        logic [QUEUE_LEVEL_BITS-1:0] level;
    } queue_status_t;

endpackage

FILE: hw/rtl/nsc_front.sv
// ----------------------------------------------------------------------------
// NAL start code splitter front end
// Takes stream bytes, tracks zero runs and start codes, holds back the most
// recent data byte and pushes zero, one or two results per byte.
// ----------------------------------------------------------------------------
module nsc_front #(
    parameter int ZERO_RUN_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // stream_byte
    input  logic                  s_tlast,   // end_of_buffer
    input  nsc_pkg::queue_status_t q_status,
    output nsc_pkg::push_t        push
);

    logic                     synced_reg, synced_next;
    logic [ZERO_RUN_BITS-1:0] run_reg, run_next;
    logic                     run_clip_reg, run_clip_next;
    logic                     have_pend_reg, have_pend_next;
    logic [7:0]               pend_byte_reg, pend_byte_next;
    logic [nsc_pkg::ZEROS_OUT_BITS-1:0] pend_zeros_reg, pend_zeros_next;
    logic                     pend_clip_reg, pend_clip_next;
    logic                     pend_first_reg, pend_first_next;

    logic                     accept;
    logic                     byte_zero;
    logic                     start_code;
    logic [31:0]              run_wide;
    logic                     run_too_wide;
    logic [nsc_pkg::ZEROS_OUT_BITS-1:0] run_out;
    logic                     emit_old;
    logic                     old_last;
    logic                     emit_new;
    nsc_pkg::result_t         res_old;
    nsc_pkg::result_t         res_new;

    assign s_tready   = q_status.ready;
    assign accept     = s_tvalid & q_status.ready;
    assign byte_zero  = (s_tdata == 8'h00);
    assign start_code = (s_tdata == 8'h01) && (|run_reg[ZERO_RUN_BITS-1:1]);

    // Clip the run to the 16-bit output field when the counter is wider.
    assign run_wide     = 32'(run_reg);
    assign run_too_wide = |run_wide[31:nsc_pkg::ZEROS_OUT_BITS];
    assign run_out      = run_too_wide ? '1 : run_wide[nsc_pkg::ZEROS_OUT_BITS-1:0];

    always_comb
    begin
        synced_next     = synced_reg;
        run_next        = run_reg;
        run_clip_next   = run_clip_reg;
        have_pend_next  = have_pend_reg;
        pend_byte_next  = pend_byte_reg;
        pend_zeros_next = pend_zeros_reg;
        pend_clip_next  = pend_clip_reg;
        pend_first_next = pend_first_reg;
        emit_old        = 1'b0;
        old_last        = 1'b0;
        emit_new        = 1'b0;

        if (accept)
        begin
            priority if (byte_zero)
            begin
                if (!(&run_reg))
                    run_next = run_reg + ZERO_RUN_BITS'(1);
                else
                    run_clip_next = 1'b1;
            end
            else if (start_code)
            begin
                // Close the held byte as the end of its unit.
                if (synced_reg && have_pend_reg)
                begin
                    emit_old = 1'b1;
                    old_last = 1'b1;
                end
                have_pend_next = 1'b0;
                synced_next    = 1'b1;
                run_next       = '0;
                run_clip_next  = 1'b0;
            end
            else
            begin
                if (synced_reg)
                begin
                    emit_old        = have_pend_reg;
                    pend_byte_next  = s_tdata;
                    pend_zeros_next = run_out;
                    pend_clip_next  = run_clip_reg | run_too_wide;
                    pend_first_next = !have_pend_reg;
                    have_pend_next  = 1'b1;
                end
                run_next      = '0;
                run_clip_next = 1'b0;
            end

            // End of buffer flushes the held byte and returns to reset state.
            if (s_tlast)
            begin
                emit_new       = synced_next && have_pend_next;
                synced_next    = 1'b0;
                run_next       = '0;
                run_clip_next  = 1'b0;
                have_pend_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res_old.unit_byte       = pend_byte_reg;
        res_old.zeros_before    = pend_zeros_reg;
        res_old.zeros_saturated = pend_clip_reg;
        res_old.first_of_unit   = pend_first_reg;
        res_old.last_of_unit    = old_last;
        res_old.final_for_input = !emit_new;

        res_new.unit_byte       = pend_byte_next;
        res_new.zeros_before    = pend_zeros_next;
        res_new.zeros_saturated = pend_clip_next;
        res_new.first_of_unit   = pend_first_next;
        res_new.last_of_unit    = 1'b1;
        res_new.final_for_input = 1'b1;

        push.count = {1'b0, emit_old} + {1'b0, emit_new};
        push.res0  = emit_old ? res_old : res_new;
        push.res1  = res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg    <= 1'b0;
            run_reg       <= '0;
            run_clip_reg  <= 1'b0;
            have_pend_reg <= 1'b0;
        end
        else
        begin
            synced_reg    <= synced_next;
            run_reg       <= run_next;
            run_clip_reg  <= run_clip_next;
            have_pend_reg <= have_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg  <= pend_byte_next;
        pend_zeros_reg <= pend_zeros_next;
        pend_clip_reg  <= pend_clip_next;
        pend_first_reg <= pend_first_next;
    end

endmodule

FILE: hw/rtl/nsc_queue.sv
// ----------------------------------------------------------------------------
// NAL start code splitter result queue
// Four-entry queue taking up to two results a cycle and giving one result a
// cycle on the output stream while downstream is ready.
// ----------------------------------------------------------------------------
module nsc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nsc_pkg::push_t         push,
    output nsc_pkg::queue_status_t q_status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,  // unit_byte, zeros_before
    output logic [2:0]             m_tuser,  // zeros_saturated, first_of_unit,
                                             // final_for_input
    output logic                   m_tlast   // last_of_unit
);

    nsc_pkg::result_t slot_reg [nsc_pkg::QUEUE_DEPTH];

    logic [nsc_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [nsc_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [nsc_pkg::QUEUE_LEVEL_BITS-1:0] level_reg, level_next;
    logic                                 pop;
    nsc_pkg::result_t                     head;

    assign pop  = m_tvalid & m_tready;
    assign head = slot_reg[rd_ptr_reg];

    // Room for the worst case of two results from the next byte.
    assign q_status.ready = (level_reg <= nsc_pkg::QUEUE_LEVEL_BITS'(nsc_pkg::QUEUE_DEPTH - 2));
    assign q_status.level = level_reg;

    assign m_tvalid = (level_reg != '0);
    assign m_tdata  = {head.zeros_before, head.unit_byte};
    assign m_tuser  = {head.final_for_input, head.first_of_unit, head.zeros_saturated};
    assign m_tlast  = head.last_of_unit;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + nsc_pkg::QUEUE_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + nsc_pkg::QUEUE_PTR_BITS'(pop);
        level_next  = level_reg + nsc_pkg::QUEUE_LEVEL_BITS'(push.count)
                      - nsc_pkg::QUEUE_LEVEL_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            slot_reg[wr_ptr_reg + nsc_pkg::QUEUE_PTR_BITS'(1)] <= push.res1;
    end

endmodule

FILE: hw/rtl/nal_start_code_splitter.sv
// ----------------------------------------------------------------------------
// NAL start code splitter
// Splits an Annex B video stream into NAL units, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
// The block takes one stream byte per request on the slave side, with tlast
// marking the last byte of a buffer, and finds start codes (two or more zero
// bytes followed by a 01 byte). Bytes before the first start code are
// dropped. Each non-zero payload byte of a unit leaves on the master side
// with the count of zero bytes before it inside the unit, a flag when that
// run was clipped, a first-of-unit flag, tlast on the unit's last byte and a
// flag on the last result caused by an input byte. Zeros trailing a unit are
// never sent and empty units give nothing. The most recent data byte is held
// back until the next data byte, start code or buffer end tells whether it
// closes its unit, so its result is pushed only when that later byte is
// accepted. The parser is combinational; results are written into the
// result queue, whose head drives the output port. The parser accepts one
// byte per cycle as long as the four-entry result queue has two free slots;
// the output drains one result per cycle while downstream is ready, so a
// byte that gives two results (a data byte that ends a buffer) puts one
// extra result on the output side, and the sustained rate is one byte per
// cycle whenever downstream keeps up. No clearing pass follows reset.
module nal_start_code_splitter #(
    parameter int ZERO_RUN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Byte stream in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  logic        s_tlast,   // end_of_buffer
    // Unit bytes out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] unit_byte, [23:8] zeros_before
    output logic [2:0]  m_tuser,   // [0] zeros_saturated, [1] first_of_unit,
                                   // [2] final_for_input
    output logic        m_tlast    // last_of_unit
);

    nsc_pkg::push_t         push;
    nsc_pkg::queue_status_t q_status;

    // The front end parses bytes and decides which results each byte causes.
    nsc_front #(
        .ZERO_RUN_BITS(ZERO_RUN_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push)
    );

    // The queue decouples the parser from a stalling downstream side.
    nsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .q_status (q_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Results are only pushed for an accepted byte.
    a_push_needs_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (s_tvalid && s_tready)
    ) else $error("results pushed without an accepted byte");

    // Two results from one byte: only the second one closes the byte.
    a_pair_final: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |->
            (push.res1.final_for_input && !push.res0.final_for_input
             && push.res1.last_of_unit)
    ) else $error("final flag misplaced in a result pair");

    // The queue never holds more than its depth.
    a_queue_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (q_status.level <= nsc_pkg::QUEUE_LEVEL_BITS'(nsc_pkg::QUEUE_DEPTH))
    ) else $error("result queue overflow");

    // Accepting a byte always leaves room for both of its results.
    a_room_on_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |->
            (q_status.level <= nsc_pkg::QUEUE_LEVEL_BITS'(nsc_pkg::QUEUE_DEPTH - 2))
    ) else $error("byte accepted without room for its results");

endmodule
